// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the script tokenizer.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with an error report.
`define STOK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define STOK_ASSERT_IMP(label, ante, cons, msg) \
    `STOK_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define STOK_ASSERT_NXT(label, ante, cons, msg) \
    `STOK_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- sv/stok_pkg.sv -----
`timescale 1ns / 1ps
// Package for the script tokenizer: sizes, character codes, enums and the
// result and bundle structs passed between the front, the queue and the back.
package stok_pkg;

    localparam int TOKEN_CHARS = 256;
    localparam int CNT_W       = $clog2(TOKEN_CHARS + 1);
    localparam int LEN_W       = 9;
    localparam int LINE_W      = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int MAX_RES     = 3;
    localparam int NRES_W      = 2;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [LINE_W-1:0] LINE_MAX   = '1;
    localparam logic [LINE_W-1:0] LINE_RESET = LINE_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE = 1'b1;

    localparam logic [7:0] CH_EOT    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_BREAK,
        KIND_EOT
    } kind_t;

    typedef enum logic [1:0] {
        CLS_WORD,
        CLS_QUOTED,
        CLS_ANGLE,
        CLS_COND
    } cls_t;

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_SLASH,
        PH_LINE,
        PH_BLOCK,
        PH_STAR,
        PH_WORD,
        PH_SCOPED
    } phase_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        cls_t             cls;
        logic [LEN_W-1:0] len;
        logic             disc;
    } res_t;

    // All results caused by one text byte, in order, with the line count.
    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [NRES_W-1:0]  n;
        logic [LINE_W-1:0]  line;
    } bundle_t;

endpackage

// ----- sv/stok_ifs.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the script tokenizer: text byte input and result output.
// Depends on stok_pkg for the field widths.
interface stok_in_if;
    import stok_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface stok_out_if;
    import stok_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [7:0]        byte_out;
    logic [1:0]        token_class;
    logic [LEN_W-1:0]  token_length;
    logic              discard;
    logic [LINE_W-1:0] line_number;
    logic              last;

    modport source (
        output valid, output kind, output byte_out, output token_class,
        output token_length, output discard, output line_number, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input byte_out, input token_class,
        input token_length, input discard, input line_number, input last,
        output ready
    );
endinterface

// ----- sv/script_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// Script tokenizer: one text byte is taken per clock cycle while the four-entry
// result queue has room, and results leave at one per cycle while the receiver
// is ready. A byte that causes no result puts nothing in the queue; the results
// of one byte (up to three) leave one after another, and the queue between the
// lexer front end and the output back end absorbs such bursts, so the input
// stalls only when results pile up faster than the output takes them. Results
// pass through a queue entry and the back-end register. Configuration writes
// take effect on the next edge; writing first_line also reloads the line
// counter. Depends on stok_pkg, stok_ifs, stok_front, stok_queue and stok_back.
module script_tokenizer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    stok_in_if.sink                         in_ch,
    stok_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [stok_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stok_pkg::CFG_DATA_W-1:0] cfg_data
);
    import stok_pkg::*;

    bundle_t push_data;
    bundle_t pop_data;
    logic    push;
    logic    push_ready;
    logic    pop;
    logic    pop_valid;

    stok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_data    (push_data)
    );

    stok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_in   (push_data),
        .in_ready  (push_ready),
        .out_valid (pop_valid),
        .pop       (pop),
        .data_out  (pop_data)
    );

    stok_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_data  (pop_data),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule

// ----- sv/stok_front.sv -----
`timescale 1ns / 1ps
// Front end of the script tokenizer: takes text bytes, runs the lexer state
// and forms one bundle of results per byte. Depends on stok_pkg, stok_in_if.
module stok_front (
    input  logic                               clk,
    input  logic                               rst_n,
    stok_in_if.sink                            in_ch,
    input  logic                               cfg_we,
    input  logic [stok_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stok_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               q_ready,
    output logic                               q_push,
    output stok_pkg::bundle_t                  q_data
);
    import stok_pkg::*;

    phase_t            phase_reg, phase_next;
    cls_t              cls_reg, cls_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              nl_seen_reg, nl_seen_next;
    logic              ended_reg, ended_next;
    logic              allow_reg;

    res_t [MAX_RES-1:0] res;
    logic [NRES_W-1:0]  n;
    logic [7:0]         c;
    logic [7:0]         endsym;
    logic [LINE_W-1:0]  line_sat;
    logic               accept;

    function automatic res_t mk_res(kind_t k, logic [7:0] d, cls_t cl,
                                    logic [CNT_W-1:0] l, logic disc);
        res_t r;
        r.kind = k;
        r.data = d;
        r.cls  = cl;
        r.len  = LEN_W'(l);
        r.disc = disc;
        return r;
    endfunction

    assign c        = in_ch.ch;
    assign line_sat = (line_reg != LINE_MAX) ? line_reg + LINE_W'(1) : line_reg;
    assign accept   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        case (cls_reg)
            CLS_QUOTED: endsym = CH_QUOTE;
            CLS_ANGLE:  endsym = CH_GT;
            default:    endsym = CH_RBRACK;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cls_next     = cls_reg;
        cnt_next     = cnt_reg;
        line_next    = line_reg;
        nl_seen_next = nl_seen_reg;
        ended_next   = ended_reg;
        res          = '0;
        n            = '0;

        if (ended_reg)
        begin
            res[n] = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
            n      = n + NRES_W'(1);
        end
        else
        begin
            case (phase_reg)
                PH_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        phase_next = PH_LINE;
                    end
                    else if (c == CH_STAR)
                    begin
                        phase_next = PH_BLOCK;
                    end
                    else
                    begin
                        // A lone slash turns out to start a word.
                        phase_next = PH_WORD;
                        res[n]     = mk_res(KIND_BYTE, CH_SLASH, CLS_WORD, '0, 1'b0);
                        n          = n + NRES_W'(1);
                        cnt_next   = CNT_W'(1);
                        if (c > CH_SPACE)
                        begin
                            res[n]   = mk_res(KIND_BYTE, c, CLS_WORD, '0, 1'b0);
                            n        = n + NRES_W'(1);
                            cnt_next = CNT_W'(2);
                        end
                        else
                        begin
                            res[n]     = mk_res(KIND_END, 8'h00, CLS_WORD, cnt_next, 1'b0);
                            n          = n + NRES_W'(1);
                            phase_next = PH_BETWEEN;
                            if (c == CH_EOT)
                            begin
                                res[n]     = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
                                n          = n + NRES_W'(1);
                                ended_next = 1'b1;
                            end
                            else if (c == CH_NL)
                            begin
                                line_next    = line_sat;
                                nl_seen_next = 1'b1;
                            end
                        end
                    end
                end

                PH_LINE:
                begin
                    if (c == CH_EOT)
                    begin
                        res[n]     = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
                        n          = n + NRES_W'(1);
                        ended_next = 1'b1;
                        phase_next = PH_BETWEEN;
                    end
                    else if (c == CH_NL)
                    begin
                        line_next    = line_sat;
                        nl_seen_next = 1'b1;
                        phase_next   = PH_BETWEEN;
                    end
                end

                PH_BLOCK, PH_STAR:
                begin
                    if (c == CH_EOT)
                    begin
                        res[n]     = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
                        n          = n + NRES_W'(1);
                        ended_next = 1'b1;
                        phase_next = PH_BETWEEN;
                    end
                    else if (phase_reg == PH_STAR && c == CH_SLASH)
                    begin
                        phase_next = PH_BETWEEN;
                    end
                    else if (c == CH_STAR)
                    begin
                        phase_next = PH_STAR;
                    end
                    else
                    begin
                        // Newlines inside a block comment count but never break.
                        if (c == CH_NL)
                        begin
                            line_next = line_sat;
                        end
                        phase_next = PH_BLOCK;
                    end
                end

                PH_WORD:
                begin
                    if (c > CH_SPACE)
                    begin
                        if (cnt_reg < CNT_W'(TOKEN_CHARS))
                        begin
                            res[n]   = mk_res(KIND_BYTE, c, CLS_WORD, '0, 1'b0);
                            n        = n + NRES_W'(1);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res[n]     = mk_res(KIND_END, 8'h00, CLS_WORD, cnt_reg,
                                            cnt_reg >= CNT_W'(TOKEN_CHARS));
                        n          = n + NRES_W'(1);
                        phase_next = PH_BETWEEN;
                        if (c == CH_EOT)
                        begin
                            res[n]     = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
                            n          = n + NRES_W'(1);
                            ended_next = 1'b1;
                        end
                        else if (c == CH_NL)
                        begin
                            line_next    = line_sat;
                            nl_seen_next = 1'b1;
                        end
                    end
                end

                PH_SCOPED:
                begin
                    if (c == endsym)
                    begin
                        // The closing bracket of a conditional is always kept.
                        if (cls_reg == CLS_COND)
                        begin
                            res[n]   = mk_res(KIND_BYTE, c, CLS_COND, '0, 1'b0);
                            n        = n + NRES_W'(1);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        res[n]     = mk_res(KIND_END, 8'h00, cls_reg, cnt_next, 1'b0);
                        n          = n + NRES_W'(1);
                        phase_next = PH_BETWEEN;
                    end
                    else if (c == CH_EOT)
                    begin
                        res[n]     = mk_res(KIND_END, 8'h00, cls_reg, cnt_reg, 1'b0);
                        n          = n + NRES_W'(1);
                        res[n]     = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
                        n          = n + NRES_W'(1);
                        ended_next = 1'b1;
                        phase_next = PH_BETWEEN;
                    end
                    else if (cnt_reg < CNT_W'(TOKEN_CHARS - 1))
                    begin
                        res[n]   = mk_res(KIND_BYTE, c, cls_reg, '0, 1'b0);
                        n        = n + NRES_W'(1);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end

                default:
                begin
                    phase_next = PH_BETWEEN;
                    if (c == CH_EOT)
                    begin
                        res[n]     = mk_res(KIND_EOT, 8'h00, CLS_WORD, '0, 1'b0);
                        n          = n + NRES_W'(1);
                        ended_next = 1'b1;
                    end
                    else if (c <= CH_SPACE)
                    begin
                        if (c == CH_NL)
                        begin
                            line_next    = line_sat;
                            nl_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (nl_seen_reg && !allow_reg)
                        begin
                            res[n] = mk_res(KIND_BREAK, 8'h00, CLS_WORD, '0, 1'b0);
                            n      = n + NRES_W'(1);
                        end
                        nl_seen_next = 1'b0;
                        cnt_next     = '0;
                        cls_next     = CLS_WORD;
                        if (c == CH_SLASH)
                        begin
                            phase_next = PH_SLASH;
                        end
                        else if (c inside {CH_QUOTE, CH_LT, CH_LBRACK})
                        begin
                            phase_next = PH_SCOPED;
                            if (c == CH_QUOTE)
                            begin
                                cls_next = CLS_QUOTED;
                            end
                            else if (c == CH_LT)
                            begin
                                cls_next = CLS_ANGLE;
                            end
                            else
                            begin
                                cls_next = CLS_COND;
                                res[n]   = mk_res(KIND_BYTE, c, CLS_COND, '0, 1'b0);
                                n        = n + NRES_W'(1);
                                cnt_next = CNT_W'(1);
                            end
                        end
                        else
                        begin
                            phase_next = PH_WORD;
                            res[n]     = mk_res(KIND_BYTE, c, CLS_WORD, '0, 1'b0);
                            n          = n + NRES_W'(1);
                            cnt_next   = CNT_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BETWEEN;
            cls_reg     <= CLS_WORD;
            cnt_reg     <= '0;
            line_reg    <= LINE_RESET;
            nl_seen_reg <= 1'b0;
            ended_reg   <= 1'b0;
            allow_reg   <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                cls_reg     <= cls_next;
                cnt_reg     <= cnt_next;
                nl_seen_reg <= nl_seen_next;
                ended_reg   <= ended_next;
            end
            // Writing first_line reloads the line counter.
            if (cfg_we && cfg_index == CFG_FIRST_LINE)
            begin
                line_reg <= cfg_data[LINE_W-1:0];
            end
            else if (accept)
            begin
                line_reg <= line_next;
            end
            if (cfg_we && cfg_index == CFG_ALLOW)
            begin
                allow_reg <= cfg_data[0];
            end
        end
    end

    assign in_ch.ready = q_ready;
    assign q_push      = accept && (n != '0);
    assign q_data.res  = res;
    assign q_data.n    = n;
    assign q_data.line = line_reg;

endmodule

// ----- sv/stok_queue.sv -----
`timescale 1ns / 1ps
// Short bundle queue between the tokenizer front and back ends.
// Depends on stok_pkg for the bundle type and depth.
module stok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stok_pkg::bundle_t data_in,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              pop,
    output stok_pkg::bundle_t data_out
);
    import stok_pkg::*;

    bundle_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;
    assign data_out  = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// ----- sv/stok_back.sv -----
`timescale 1ns / 1ps
// Back end of the script tokenizer: holds one bundle and hands out its results
// one transfer at a time. Depends on stok_pkg and stok_out_if.
module stok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  stok_pkg::bundle_t q_data,
    output logic              q_pop,
    stok_out_if.source        out_ch
);
    import stok_pkg::*;

    bundle_t           cur_reg;
    logic              cur_valid_reg;
    logic [NRES_W-1:0] idx_reg;
    res_t              cur_res;
    logic              is_last;
    logic              out_fire;

    assign cur_res  = cur_reg.res[idx_reg];
    assign is_last  = (idx_reg == cur_reg.n - NRES_W'(1));
    assign out_fire = cur_valid_reg && out_ch.ready;
    // The next bundle moves in on the same edge as the last result leaves.
    assign q_pop    = q_valid && (!cur_valid_reg || (out_fire && is_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_fire && is_last)
            begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + NRES_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    assign out_ch.valid        = cur_valid_reg;
    assign out_ch.kind         = cur_res.kind;
    assign out_ch.byte_out     = cur_res.data;
    assign out_ch.token_class  = cur_res.cls;
    assign out_ch.token_length = cur_res.len;
    assign out_ch.discard      = cur_res.disc;
    assign out_ch.line_number  = cur_reg.line;
    assign out_ch.last         = is_last;

endmodule

// ----- sv/stok_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the result channel of the script tokenizer, bound to
// the top level. Depends on stok_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stok_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    out_kind,
    input logic [7:0]                    out_byte,
    input logic [stok_pkg::LINE_W-1:0]   out_line,
    input logic                          out_last
);
    import stok_pkg::*;

    logic eot_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eot_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && out_kind == KIND_EOT)
        begin
            eot_seen_reg <= 1'b1;
        end
    end

    `STOK_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_byte), "result changed while stalled")

    // Results of one byte are sent back to back and share a line count.
    `STOK_ASSERT_NXT(a_bundle_line, out_valid && out_ready && !out_last,
        out_valid && $stable(out_line), "result group broken or line count changed")

    `STOK_ASSERT_IMP(a_eot_sticky, eot_seen_reg && out_valid,
        out_kind == KIND_EOT, "result other than end of text after end of text")

    `STOK_ASSERT_IMP(a_eot_last, out_valid && out_kind == KIND_EOT,
        out_last, "end of text is not the last result of its byte")

endmodule

bind script_tokenizer_unit stok_checker u_stok_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_byte  (out_ch.byte_out),
    .out_line  (out_ch.line_number),
    .out_last  (out_ch.last)
);
